/* design/tlbpt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the TLB page table translator.
// No dependencies.
package tlbpt_pkg;

   localparam int TLB_ENTRIES = 16;
   localparam int PAGE_COUNT  = 256;
   localparam int PAGE_BYTES  = 256;

   localparam int ADDR_BITS    = 16;
   localparam int OFFSET_BITS  = $clog2(PAGE_BYTES);
   localparam int PAGE_BITS    = $clog2(PAGE_COUNT);
   localparam int FRAME_BITS   = 8;
   localparam int FREE_BITS    = $clog2(PAGE_COUNT + 1);
   localparam int TLB_IDX_BITS = $clog2(TLB_ENTRIES);
   localparam int STAMP_BITS   = 32;
   localparam int COUNT_BITS   = 32;
   localparam int STATUS_BITS  = 2;
   localparam int LRU_GROUP    = 4;
   localparam int LRU_GROUPS   = TLB_ENTRIES / LRU_GROUP;
   localparam int GROUP_BITS   = $clog2(LRU_GROUPS);

   localparam logic POLICY_FIFO  = 1'b0;
   localparam logic POLICY_LRU   = 1'b1;
   localparam logic POLICY_RESET = POLICY_LRU;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_TLB_HIT   = 2'd0,
      ST_MAP_HIT   = 2'd1,
      ST_FAULT     = 2'd2,
      ST_NO_MEMORY = 2'd3
   } tlbpt_code_type;

   typedef logic [TLB_ENTRIES-1:0][STAMP_BITS-1:0] tlbpt_stamp_array_type;

   typedef struct packed {
      logic load_addr;
      logic lookup;
      logic resolve;
   } tlbpt_cmd_type;

   typedef struct packed {
      logic tlb_hit;
   } tlbpt_stat_type;

endpackage

/* design/tlb_page_table_translator.sv */
`timescale 1ns / 1ps
// Top level of the TLB page table translator: sequencer plus datapath.
// Depends on tlbpt_pkg, tlbpt_ctrl and tlbpt_datapath.
//
// Use: drive req_logical_address with start high while busy is low; the beat
// is taken at that edge and busy rises until the lookup is done. One result
// beat follows per request, marked by rsp_strobe for exactly one cycle; the
// receiver has no way to hold it off and must take it then.
// On a TLB hit the result comes from one parallel tag compare; on a miss the
// page map memory read in the lookup state is followed by LRU victim
// selection, refill and page map write-back together in the resolve state.
// A new request can be accepted in the cycle the previous result is shown;
// no request is taken while another is still in lookup or resolve.
// The counts on the result beat include that beat's own event.
// csr_write_data sets the refill policy (0 FIFO, 1 LRU) at an edge where
// csr_write_enable is high; write it only while idle.
// Reset (synchronous, active high) empties the TLB and the page map at once,
// restarts frame allocation at frame 0, zeroes the counters and selects LRU.
module tlb_page_table_translator import tlbpt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ADDR_BITS-1:0]   req_logical_address,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   output logic                   rsp_strobe,
   output logic [ADDR_BITS-1:0]   rsp_phys_addr,
   output logic [FRAME_BITS-1:0]  rsp_frame,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [COUNT_BITS-1:0]  rsp_hit_count,
   output logic [COUNT_BITS-1:0]  rsp_miss_count,
   output logic [COUNT_BITS-1:0]  rsp_fault_count
);

   tlbpt_cmd_type  cmd;
   tlbpt_stat_type stat;

   tlbpt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   tlbpt_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_logical_address (req_logical_address),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_phys_addr       (rsp_phys_addr),
      .rsp_frame           (rsp_frame),
      .rsp_status          (rsp_status),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_miss_count      (rsp_miss_count),
      .rsp_fault_count     (rsp_fault_count)
   );

endmodule

/* design/tlbpt_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the translator: idle, TLB lookup, page map resolve.
// Depends on tlbpt_pkg.
module tlbpt_ctrl import tlbpt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  tlbpt_stat_type stat,
   output tlbpt_cmd_type  cmd,
   output logic           busy
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_RESOLVE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = stat.tlb_hit ? S_IDLE : S_RESOLVE;
         end
         S_RESOLVE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign cmd.load_addr = (state_ff == S_IDLE) && start && !busy_ff;
   assign cmd.lookup    = (state_ff == S_LOOKUP);
   assign cmd.resolve   = (state_ff == S_RESOLVE);
   assign busy          = busy_ff;

`ifndef SYNTH
   a_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != S_IDLE))
      else $error("busy out of step with state");
   a_resolve_after_miss: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESOLVE |-> $past(state_ff) == S_LOOKUP && !$past(stat.tlb_hit))
      else $error("resolve without a TLB miss");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_addr, cmd.lookup, cmd.resolve}))
      else $error("overlapping commands");
`endif

endmodule

/* design/tlbpt_lru.sv */
`timescale 1ns / 1ps
// Two-level registered minimum tree over the TLB stamps; picks the LRU victim.
// Depends on tlbpt_pkg.
module tlbpt_lru import tlbpt_pkg::*; (
   input  logic                    clock,
   input  tlbpt_stamp_array_type   stamps,
   output logic [TLB_IDX_BITS-1:0] victim
);

   logic [LRU_GROUPS-1:0][STAMP_BITS-1:0]   cand_stamp_in, cand_stamp_ff;
   logic [LRU_GROUPS-1:0][TLB_IDX_BITS-1:0] cand_idx_in, cand_idx_ff;

   // first level: minimum inside each group, lowest index on ties
   always_comb begin
      for (int g = 0; g < LRU_GROUPS; g++) begin
         cand_stamp_in[g] = stamps[g*LRU_GROUP];
         cand_idx_in[g]   = TLB_IDX_BITS'(g*LRU_GROUP);
         for (int k = 1; k < LRU_GROUP; k++) begin
            if (stamps[g*LRU_GROUP+k] < cand_stamp_in[g]) begin
               cand_stamp_in[g] = stamps[g*LRU_GROUP+k];
               cand_idx_in[g]   = TLB_IDX_BITS'(g*LRU_GROUP+k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_stamp_ff <= cand_stamp_in;
      cand_idx_ff   <= cand_idx_in;
   end

   // second level: minimum over the group winners
   always_comb begin
      logic [STAMP_BITS-1:0] best;
      best   = cand_stamp_ff[0];
      victim = cand_idx_ff[0];
      for (int g = 1; g < LRU_GROUPS; g++) begin
         if (cand_stamp_ff[g] < best) begin
            best   = cand_stamp_ff[g];
            victim = cand_idx_ff[g];
         end
      end
   end

endmodule

/* design/tlbpt_datapath.sv */
`timescale 1ns / 1ps
// Datapath: TLB registers, page map, frame allocator, counters, result registers.
// Depends on tlbpt_pkg and tlbpt_lru.
module tlbpt_datapath import tlbpt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  tlbpt_cmd_type          cmd,
   output tlbpt_stat_type         stat,
   input  logic [ADDR_BITS-1:0]   req_logical_address,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   output logic                   rsp_strobe,
   output logic [ADDR_BITS-1:0]   rsp_phys_addr,
   output logic [FRAME_BITS-1:0]  rsp_frame,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [COUNT_BITS-1:0]  rsp_hit_count,
   output logic [COUNT_BITS-1:0]  rsp_miss_count,
   output logic [COUNT_BITS-1:0]  rsp_fault_count
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

   logic                    policy_ff;
   logic [ADDR_BITS-1:0]    addr_ff;
   logic [PAGE_BITS-1:0]    page;
   logic [OFFSET_BITS-1:0]  offset;

   logic [TLB_ENTRIES-1:0]                     tlb_valid_ff;
   logic [TLB_ENTRIES-1:0][PAGE_BITS-1:0]      tlb_tag_ff;
   logic [TLB_ENTRIES-1:0][FRAME_BITS-1:0]     tlb_frame_ff;
   tlbpt_stamp_array_type                      tlb_stamp_ff;
   logic [TLB_IDX_BITS-1:0]                    fifo_ptr_ff, fifo_ptr_in;

   logic [PAGE_COUNT-1:0]   map_valid_ff;
   logic [FRAME_BITS-1:0]   map_mem [PAGE_COUNT];
   logic [FRAME_BITS-1:0]   map_rdata_ff;
   logic [FREE_BITS-1:0]    next_free_ff, next_free_in;

   logic [STAMP_BITS-1:0]   clock_ff, clock_in;
   logic [COUNT_BITS-1:0]   hits_ff, hits_in, misses_ff, misses_in, faults_ff, faults_in;

   logic                    hit;
   logic [TLB_IDX_BITS-1:0] hit_idx;
   logic [TLB_IDX_BITS-1:0] lru_victim, victim;
   logic                    map_hit, alloc_ok, refill, fault;
   logic [FRAME_BITS-1:0]   res_frame;
   tlbpt_code_type          res_code;

   logic                    rsp_valid_ff;
   logic [ADDR_BITS-1:0]    rsp_phys_ff;
   logic [FRAME_BITS-1:0]   rsp_frame_ff;
   tlbpt_code_type          rsp_code_ff;

   assign page   = addr_ff[OFFSET_BITS +: PAGE_BITS];
   assign offset = addr_ff[OFFSET_BITS-1:0];

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && tlb_tag_ff[i] == page) begin
            hit     = 1'b1;
            hit_idx = TLB_IDX_BITS'(i);
         end
      end
   end
   assign stat.tlb_hit = hit;

   tlbpt_lru u_lru (
      .clock  (clock),
      .stamps (tlb_stamp_ff),
      .victim (lru_victim)
   );

   assign map_hit  = map_valid_ff[page];
   assign alloc_ok = (next_free_ff < FREE_BITS'(PAGE_COUNT));
   assign fault    = cmd.resolve && !map_hit && alloc_ok;
   assign refill   = cmd.resolve && (map_hit || alloc_ok);
   assign victim   = (policy_ff == POLICY_LRU) ? lru_victim : fifo_ptr_ff;

   always_comb begin
      if (map_hit) begin
         res_frame = map_rdata_ff;
         res_code  = ST_MAP_HIT;
      end else if (alloc_ok) begin
         res_frame = next_free_ff[FRAME_BITS-1:0];
         res_code  = ST_FAULT;
      end else begin
         res_frame = '0;
         res_code  = ST_NO_MEMORY;
      end
   end

   always_comb begin
      clock_in     = clock_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      faults_in    = faults_ff;
      next_free_in = next_free_ff;
      fifo_ptr_in  = fifo_ptr_ff;
      if (cmd.lookup) begin
         if (clock_ff != STAMP_MAX) clock_in = clock_ff + 1'b1;
         if (hit) begin
            if (hits_ff != COUNT_MAX) hits_in = hits_ff + 1'b1;
         end else begin
            if (misses_ff != COUNT_MAX) misses_in = misses_ff + 1'b1;
         end
      end
      if (fault) begin
         next_free_in = next_free_ff + 1'b1;
         if (faults_ff != COUNT_MAX) faults_in = faults_ff + 1'b1;
      end
      if (refill) begin
         fifo_ptr_in = (fifo_ptr_ff == TLB_IDX_BITS'(TLB_ENTRIES - 1)) ? '0
                                                                       : fifo_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_RESET;
         tlb_valid_ff <= '0;
         tlb_stamp_ff <= '0;
         fifo_ptr_ff  <= '0;
         map_valid_ff <= '0;
         next_free_ff <= '0;
         clock_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) policy_ff <= csr_write_data;
         fifo_ptr_ff  <= fifo_ptr_in;
         next_free_ff <= next_free_in;
         clock_ff     <= clock_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= (cmd.lookup && hit) || cmd.resolve;
         if (cmd.lookup && hit && policy_ff == POLICY_LRU) tlb_stamp_ff[hit_idx] <= clock_in;
         if (refill) begin
            tlb_valid_ff[victim] <= 1'b1;
            tlb_stamp_ff[victim] <= clock_ff;
         end
         if (fault) map_valid_ff[page] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_addr) addr_ff <= req_logical_address;
      if (refill) begin
         tlb_tag_ff[victim]   <= page;
         tlb_frame_ff[victim] <= res_frame;
      end
      if (cmd.lookup) map_rdata_ff <= map_mem[page];
      if (fault) map_mem[page] <= res_frame;
      if (cmd.lookup && hit) begin
         rsp_frame_ff <= tlb_frame_ff[hit_idx];
         rsp_phys_ff  <= ADDR_BITS'({tlb_frame_ff[hit_idx], offset});
         rsp_code_ff  <= ST_TLB_HIT;
      end else if (cmd.resolve) begin
         rsp_frame_ff <= res_frame;
         rsp_phys_ff  <= (res_code == ST_NO_MEMORY) ? '0 : ADDR_BITS'({res_frame, offset});
         rsp_code_ff  <= res_code;
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_phys_addr   = rsp_phys_ff;
   assign rsp_frame       = rsp_frame_ff;
   assign rsp_status      = rsp_code_ff;
   assign rsp_hit_count   = hits_ff;
   assign rsp_miss_count  = misses_ff;
   assign rsp_fault_count = faults_ff;

`ifndef SYNTH
   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_BITS'(PAGE_COUNT))
      else $error("frame allocator past the end");
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_code_ff == ST_FAULT |-> faults_ff != '0)
      else $error("fault reported with zero fault count");
   a_no_memory_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_code_ff == ST_NO_MEMORY |-> next_free_ff == FREE_BITS'(PAGE_COUNT))
      else $error("out of memory with frames left");
   a_refill_validates: assert property (@(posedge clock) disable iff (reset)
      refill |=> tlb_valid_ff[$past(victim)])
      else $error("refilled entry not valid");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of tlb_page_table_translator: directed and random
// address beats, a translation predictor in a scoreboard class, both policies.
// Depends on tlbpt_pkg and tlb_page_table_translator.
module tb;
   import tlbpt_pkg::*;

   localparam int MAX_CYCLES  = 400000;
   localparam int PHASE_ITEMS = 180;
   localparam int HOT_MAX     = 24;

   typedef struct {
      logic [ADDR_BITS-1:0]  phys;
      logic [FRAME_BITS-1:0] frame;
      tlbpt_code_type        status;
      logic [COUNT_BITS-1:0] hits;
      logic [COUNT_BITS-1:0] misses;
      logic [COUNT_BITS-1:0] faults;
   } translation_type;

   class scoreboard_type;
      int errors;
      translation_type pending_translations[$];
      logic policy;
      logic [PAGE_BITS-1:0]  tlb_tag[TLB_ENTRIES];
      logic [FRAME_BITS-1:0] tlb_frame[TLB_ENTRIES];
      bit tlb_valid[TLB_ENTRIES];
      logic [STAMP_BITS-1:0] tlb_stamp[TLB_ENTRIES];
      logic [TLB_IDX_BITS-1:0] fifo_ptr;
      bit map_valid[PAGE_COUNT];
      logic [FRAME_BITS-1:0] map_frame[PAGE_COUNT];
      int next_free;
      logic [STAMP_BITS-1:0] ticks;
      logic [COUNT_BITS-1:0] hits, misses, faults;

      function new();
         errors = 0;
         policy = POLICY_RESET;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_tag[i] = '0;
            tlb_frame[i] = '0;
            tlb_valid[i] = 0;
            tlb_stamp[i] = '0;
         end
         for (int p = 0; p < PAGE_COUNT; p++) begin
            map_valid[p] = 0;
            map_frame[p] = '0;
         end
         fifo_ptr = '0;
         next_free = 0;
         ticks = '0;
         hits = '0;
         misses = '0;
         faults = '0;
      endfunction

      function logic [31:0] sat_inc(logic [31:0] v);
         return (v == '1) ? v : v + 1;
      endfunction

      function int pick_victim();
         int best;
         if (policy == POLICY_FIFO) return int'(fifo_ptr);
         best = 0;
         for (int i = 1; i < TLB_ENTRIES; i++)
            if (tlb_stamp[i] < tlb_stamp[best]) best = i;
         return best;
      endfunction

      function translation_type predict_translation(logic [ADDR_BITS-1:0] addr);
         translation_type t;
         logic [PAGE_BITS-1:0] page;
         logic [OFFSET_BITS-1:0] offset;
         logic [FRAME_BITS-1:0] frm;
         bit hit, have;
         int v;
         page = addr[ADDR_BITS-1:OFFSET_BITS];
         offset = addr[OFFSET_BITS-1:0];
         frm = '0;
         hit = 0;
         have = 1;
         ticks = sat_inc(ticks);
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && tlb_valid[i] && tlb_tag[i] == page) begin
               hit = 1;
               frm = tlb_frame[i];
               if (policy == POLICY_LRU) tlb_stamp[i] = ticks;
            end
         end
         if (hit) begin
            hits = sat_inc(hits);
            t.status = ST_TLB_HIT;
         end else begin
            misses = sat_inc(misses);
            if (map_valid[page]) begin
               frm = map_frame[page];
               t.status = ST_MAP_HIT;
            end else if (next_free < PAGE_COUNT) begin
               frm = FRAME_BITS'(next_free);
               next_free++;
               map_valid[page] = 1;
               map_frame[page] = frm;
               faults = sat_inc(faults);
               t.status = ST_FAULT;
            end else begin
               have = 0;
               t.status = ST_NO_MEMORY;
            end
            if (have) begin
               v = pick_victim();
               tlb_tag[v] = page;
               tlb_frame[v] = frm;
               tlb_stamp[v] = ticks;
               tlb_valid[v] = 1;
               fifo_ptr = fifo_ptr + 1'b1;
            end
         end
         if (t.status == ST_NO_MEMORY) begin
            t.phys = '0;
            t.frame = '0;
         end else begin
            t.phys = {frm, offset};
            t.frame = frm;
         end
         t.hits = hits;
         t.misses = misses;
         t.faults = faults;
         return t;
      endfunction

      function void set_policy(logic value);
         policy = value;
      endfunction

      function void note_request(logic [ADDR_BITS-1:0] addr);
         pending_translations.push_back(predict_translation(addr));
      endfunction

      function int pending();
         return pending_translations.size();
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 200) $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      task check_response(logic [ADDR_BITS-1:0] phys, logic [FRAME_BITS-1:0] frame,
                          logic [STATUS_BITS-1:0] status, logic [COUNT_BITS-1:0] h,
                          logic [COUNT_BITS-1:0] m, logic [COUNT_BITS-1:0] f);
         translation_type t;
         if (pending_translations.size() == 0) begin
            report_mismatch("result beat with no request outstanding");
            return;
         end
         t = pending_translations.pop_front();
         if (phys !== t.phys)
            report_mismatch($sformatf("phys_addr %h, exp %h", phys, t.phys));
         if (frame !== t.frame)
            report_mismatch($sformatf("frame %h, exp %h", frame, t.frame));
         if (status !== t.status)
            report_mismatch($sformatf("status %0d, exp %0d", status, t.status));
         if (h !== t.hits)
            report_mismatch($sformatf("hit_count %0d, exp %0d", h, t.hits));
         if (m !== t.misses)
            report_mismatch($sformatf("miss_count %0d, exp %0d", m, t.misses));
         if (f !== t.faults)
            report_mismatch($sformatf("fault_count %0d, exp %0d", f, t.faults));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [ADDR_BITS-1:0]   req_logical_address;
   logic                   csr_write_enable;
   logic                   csr_write_data;
   logic                   rsp_strobe;
   logic [ADDR_BITS-1:0]   rsp_phys_addr;
   logic [FRAME_BITS-1:0]  rsp_frame;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [COUNT_BITS-1:0]  rsp_hit_count;
   logic [COUNT_BITS-1:0]  rsp_miss_count;
   logic [COUNT_BITS-1:0]  rsp_fault_count;

   scoreboard_type board = new();
   int cycles = 0;
   logic [PAGE_BITS-1:0] hot_pages[HOT_MAX];
   int hot_count;

   tlb_page_table_translator u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_logical_address (req_logical_address),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_phys_addr       (rsp_phys_addr),
      .rsp_frame           (rsp_frame),
      .rsp_status          (rsp_status),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_miss_count      (rsp_miss_count),
      .rsp_fault_count     (rsp_fault_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("tlb_page_table_translator verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1)
         board.check_response(rsp_phys_addr, rsp_frame, rsp_status,
                              rsp_hit_count, rsp_miss_count, rsp_fault_count);
   end

   // one request beat; returns at the falling edge after acceptance, start left high
   task send_item(logic [ADDR_BITS-1:0] addr);
      start <= 1'b1;
      req_logical_address <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(addr);
      @(negedge clock);
   endtask

   task idle_for(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task drain();
      start <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      @(negedge clock);
   endtask

   task write_policy(logic value);
      drain();
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      board.set_policy(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function logic [ADDR_BITS-1:0] random_address();
      if ($urandom_range(0, 49) == 0)
         hot_pages[$urandom_range(0, hot_count - 1)] = PAGE_BITS'($urandom);
      if ($urandom_range(0, 99) < 75)
         return {hot_pages[$urandom_range(0, hot_count - 1)], OFFSET_BITS'($urandom)};
      return ADDR_BITS'($urandom);
   endfunction

   initial begin
      logic [ADDR_BITS-1:0] directed[$];
      logic [PAGE_BITS-1:0] sweep[PAGE_COUNT];
      logic [PAGE_BITS-1:0] tmp;
      int j;
      bit quiet;

      reset = 1'b1;
      start = 1'b0;
      req_logical_address = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // LRU out of reset: corners, repeats for TLB hits, then overflow the TLB
      directed = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h5AA5, 16'hA55A};
      for (int p = 1; p <= TLB_ENTRIES; p++)
         directed.push_back({PAGE_BITS'(p), OFFSET_BITS'($urandom)});
      directed.push_back(16'h0001);
      foreach (directed[i]) begin
         send_item(directed[i]);
         idle_for(pick_gap(i < 8));
      end

      for (int ph = 0; ph < 8; ph++) begin
         write_policy(ph < 4 ? logic'(ph % 2) : logic'($urandom_range(0, 1)));
         quiet = (ph == 3);
         hot_count = $urandom_range(4, HOT_MAX);
         for (int i = 0; i < HOT_MAX; i++) hot_pages[i] = PAGE_BITS'($urandom);
         if (ph == 2) begin
            for (int p = 0; p < PAGE_COUNT; p++) sweep[p] = PAGE_BITS'(p);
            for (int p = PAGE_COUNT - 1; p > 0; p--) begin
               j = $urandom_range(0, p);
               tmp = sweep[p];
               sweep[p] = sweep[j];
               sweep[j] = tmp;
            end
            for (int p = 0; p < PAGE_COUNT; p++) begin
               send_item({sweep[p], OFFSET_BITS'($urandom)});
               idle_for(pick_gap(1'b0));
            end
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_item(random_address());
            if ($urandom_range(0, 99) == 0) drain();
            else idle_for(pick_gap(quiet));
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (board.pending() > 0)
         board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
      if (board.errors == 0)
         $display("tlb_page_table_translator verification clean");
      else
         $display("tlb_page_table_translator verification failed");
      $finish;
   end
endmodule
